// File: rtl/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared constants, controller states, datapath operations and status.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int TABLE_SIZE    = 256;
  localparam int IDX_W         = 8;
  localparam int MAX_KEY_BYTES = 256;
  localparam int KEY_CNT_W     = 9;

  localparam logic [1:0] FUNC_KEY  = 2'd0;
  localparam logic [1:0] FUNC_DATA = 2'd1;
  localparam logic [1:0] FUNC_SKIP = 2'd2;

  typedef enum logic [3:0] {
    ST_RST_FILL,
    ST_KEY_FILL,
    ST_IDLE,
    ST_KS_J,
    ST_KS_I,
    ST_KS_SJ,
    ST_KS_OUT,
    ST_SC_RD,
    ST_SC_A,
    ST_SC_K,
    ST_SC_SA
  } rc4_state_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_FILL,
    OP_KEY,
    OP_KEY_LAST,
    OP_KS_START,
    OP_KS_RD_J,
    OP_KS_SW_I,
    OP_KS_SW_J,
    OP_KS_OUT,
    OP_SC_RD,
    OP_SC_RD_A,
    OP_SC_SW_K,
    OP_SC_SW_A
  } rc4_op_t;

  typedef struct packed {
    logic k_last;
    logic out_full;
  } rc4_stat_t;

endpackage

// File: rtl/rc4_ram.sv
// ----------------------------------------------------------------------------
// rc4_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/rc4_dp.sv
// ----------------------------------------------------------------------------
// rc4_dp
// Datapath: sbox and key memories, indices, counters and output register.
// ----------------------------------------------------------------------------
module rc4_dp
  import rc4_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  rc4_op_t          op,
  output rc4_stat_t        stat,
  input  logic [7:0]       data_in,
  output logic [7:0]       data_out,
  output logic             out_valid,
  input  logic             out_ready
);

  logic [IDX_W-1:0]     idx_i, idx_j, si, sj, acc, k, kidx, data_reg;
  logic                 hit;
  logic [KEY_CNT_W-1:0] key_count, key_len, count_after;
  logic                 key_full;

  logic             sb_we, sb_re, kr_we, kr_re;
  logic [IDX_W-1:0] sb_waddr, sb_wdata, sb_raddr, sb_rdata, kr_rdata;
  logic [IDX_W-1:0] j_sum, acc_sum, t_addr, i_inc;

  assign key_full    = (key_count == KEY_CNT_W'(MAX_KEY_BYTES));
  assign count_after = key_full ? key_count : key_count + KEY_CNT_W'(1);
  assign j_sum       = idx_j + sb_rdata;
  assign acc_sum     = acc + sb_rdata + kr_rdata;
  assign t_addr      = si + sj;
  assign i_inc       = idx_i + IDX_W'(1);

  assign stat.k_last   = (k == IDX_W'(TABLE_SIZE - 1));
  assign stat.out_full = out_valid && !out_ready;

  assign kr_we = (op == OP_KEY || op == OP_KEY_LAST) && !key_full;
  assign kr_re = (op == OP_SC_RD);

  always_comb begin
    sb_we    = 1'b0;
    sb_waddr = k;
    sb_wdata = k;
    sb_re    = 1'b0;
    sb_raddr = k;
    unique case (op)
      OP_FILL: begin
        sb_we = 1'b1;
      end
      OP_KS_START: begin
        sb_re    = 1'b1;
        sb_raddr = i_inc;
      end
      OP_KS_RD_J: begin
        sb_re    = 1'b1;
        sb_raddr = j_sum;
      end
      OP_KS_SW_I: begin
        sb_we    = 1'b1;
        sb_waddr = idx_i;
        sb_wdata = sb_rdata;
      end
      OP_KS_SW_J: begin
        sb_we    = 1'b1;
        sb_waddr = idx_j;
        sb_wdata = si;
        sb_re    = 1'b1;
        sb_raddr = t_addr;
      end
      OP_SC_RD: begin
        sb_re = 1'b1;
      end
      OP_SC_RD_A: begin
        sb_re    = 1'b1;
        sb_raddr = acc_sum;
      end
      OP_SC_SW_K: begin
        sb_we    = 1'b1;
        sb_wdata = sb_rdata;
      end
      OP_SC_SW_A: begin
        sb_we    = 1'b1;
        sb_waddr = acc;
        sb_wdata = si;
      end
      default: begin
      end
    endcase
  end

  rc4_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_SIZE)) u_sbox (
    .clk   (clk),
    .we    (sb_we),
    .waddr (sb_waddr),
    .wdata (sb_wdata),
    .re    (sb_re),
    .raddr (sb_raddr),
    .rdata (sb_rdata)
  );

  rc4_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_SIZE)) u_key (
    .clk   (clk),
    .we    (kr_we),
    .waddr (key_count[IDX_W-1:0]),
    .wdata (data_in),
    .re    (kr_re),
    .raddr (kidx),
    .rdata (kr_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      idx_i     <= '0;
      idx_j     <= '0;
      k         <= '0;
      key_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (op)
        OP_FILL: begin
          k <= k + IDX_W'(1);
        end
        OP_KEY: begin
          key_count <= count_after;
        end
        OP_KEY_LAST: begin
          key_len   <= count_after;
          key_count <= '0;
          k         <= '0;
        end
        OP_KS_START: begin
          idx_i <= i_inc;
        end
        OP_KS_RD_J: begin
          idx_j <= j_sum;
        end
        OP_KS_OUT: begin
          out_valid <= 1'b1;
        end
        OP_SC_SW_A: begin
          k <= k + IDX_W'(1);
          if (stat.k_last) begin
            idx_i <= '0;
            idx_j <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (op)
      OP_KEY_LAST: begin
        kidx <= '0;
        acc  <= '0;
      end
      OP_KS_START: begin
        data_reg <= data_in;
      end
      OP_KS_RD_J: begin
        si <= sb_rdata;
      end
      OP_KS_SW_I: begin
        sj <= sb_rdata;
      end
      OP_KS_SW_J: begin
        hit <= (t_addr == idx_j);
      end
      OP_KS_OUT: begin
        data_out <= data_reg ^ (hit ? si : sb_rdata);
      end
      OP_SC_RD_A: begin
        si  <= sb_rdata;
        acc <= acc_sum;
      end
      OP_SC_SW_A: begin
        kidx <= (({1'b0, kidx} + KEY_CNT_W'(1)) == key_len) ? '0 : kidx + IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/rc4_ctrl.sv
// ----------------------------------------------------------------------------
// rc4_ctrl
// Controller: sequences table fill, key schedule and keystream steps.
// ----------------------------------------------------------------------------
module rc4_ctrl
  import rc4_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] func,
  input  logic       last_key,
  input  rc4_stat_t  stat,
  output rc4_op_t    op
);

  rc4_state_t state, state_next;
  logic       emit, emit_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RST_FILL;
      emit  <= 1'b0;
    end else begin
      state <= state_next;
      emit  <= emit_next;
    end
  end

  always_comb begin
    state_next = state;
    emit_next  = emit;
    op         = OP_NOP;
    in_ready   = 1'b0;
    unique case (state)
      ST_RST_FILL: begin
        op = OP_FILL;
        if (stat.k_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_KEY_FILL: begin
        op = OP_FILL;
        if (stat.k_last) begin
          state_next = ST_SC_RD;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (func)
            FUNC_KEY: begin
              if (last_key) begin
                op         = OP_KEY_LAST;
                state_next = ST_KEY_FILL;
              end else begin
                op = OP_KEY;
              end
            end
            FUNC_DATA, FUNC_SKIP: begin
              op         = OP_KS_START;
              emit_next  = (func == FUNC_DATA);
              state_next = ST_KS_J;
            end
            default: begin
            end
          endcase
        end
      end
      ST_KS_J: begin
        op         = OP_KS_RD_J;
        state_next = ST_KS_I;
      end
      ST_KS_I: begin
        op         = OP_KS_SW_I;
        state_next = ST_KS_SJ;
      end
      ST_KS_SJ: begin
        op         = OP_KS_SW_J;
        state_next = emit ? ST_KS_OUT : ST_IDLE;
      end
      ST_KS_OUT: begin
        if (!stat.out_full) begin
          op         = OP_KS_OUT;
          state_next = ST_IDLE;
        end
      end
      ST_SC_RD: begin
        op         = OP_SC_RD;
        state_next = ST_SC_A;
      end
      ST_SC_A: begin
        op         = OP_SC_RD_A;
        state_next = ST_SC_K;
      end
      ST_SC_K: begin
        op         = OP_SC_SW_K;
        state_next = ST_SC_SA;
      end
      ST_SC_SA: begin
        op         = OP_SC_SW_A;
        state_next = stat.k_last ? ST_IDLE : ST_SC_RD;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/rc4_stream_cipher_top.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher_top
// RC4 stream cipher: key load, key schedule and keystream XOR.
// ----------------------------------------------------------------------------
// After reset the block writes the identity into the sbox and accepts no
// item meanwhile. A key byte without the last flag is only stored. The last
// key byte starts an identity fill and then the key schedule, each swap step
// of which reads S[k] and S[acc] and then writes both. A data item reads S[i]
// and S[j], swaps them, reads S[S[i]+S[j]] and registers the result; a skip
// item registers none. A data item also waits while the previous result is
// not taken. The single sbox memory does one read and one write per cycle.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_top
  import rc4_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] func,
  input  logic [7:0] data_in,
  input  logic       last_key,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_out
);

  rc4_op_t   op;
  rc4_stat_t stat;

  rc4_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .last_key (last_key),
    .stat     (stat),
    .op       (op)
  );

  rc4_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .stat      (stat),
    .data_in   (data_in),
    .data_out  (data_out),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

`ifndef SYNTHESIS
  a_data_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func == FUNC_DATA && !out_valid |-> ##5 out_valid)
    else $error("data transfer did not produce a result");

  a_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func != FUNC_DATA && !out_valid |=> !out_valid)
    else $error("result from a non-data transfer");

  a_busy_after_key: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func == FUNC_KEY && last_key |=> !in_ready)
    else $error("input taken during key schedule");
`endif

endmodule

// File: verif/rc4_stream_cipher_top_test.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher_top_test
// Self-checking bench for the RC4 cipher block. A queue-fed driver sends
// key, data and skip transfers. A clocked monitor tracks the sbox, the key
// bytes and the stream indices, and compares each ciphered byte with the
// oldest prediction. Sender and receiver idle at several rates across phases.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_top_test
  import rc4_pkg::*;
();

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int DRAIN_CYCLES = 1400;
  localparam int RUN_LIMIT = 2000000;
  localparam int ITEMS_PER_PHASE = 200;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data;
    logic       last;
  } cipher_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] func = FUNC_DATA;
  logic [7:0] data_in = 8'h00;
  logic       last_key = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] data_out;

  cipher_item_t pending_items[$];
  logic [7:0]   expected_cipher[$];
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           mismatch_count = 0;
  int           items_queued = 0;

  logic [7:0]  sbox_state[TABLE_SIZE];
  logic [7:0]  key_bytes[TABLE_SIZE];
  int unsigned keys_stored;
  logic [7:0]  stream_i;
  logic [7:0]  stream_j;

  rc4_stream_cipher_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .data_in  (data_in),
    .last_key (last_key),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .data_out (data_out)
  );

  always #1 clk = ~clk;

  function automatic void fill_identity();
    for (int k = 0; k < TABLE_SIZE; k++) begin
      sbox_state[k] = 8'(k);
    end
  endfunction

  function automatic void run_key_schedule(int unsigned len);
    logic [7:0] acc;
    logic [7:0] t;
    acc = 8'h00;
    fill_identity();
    for (int k = 0; k < TABLE_SIZE; k++) begin
      acc = acc + sbox_state[k] + key_bytes[k % len];
      t = sbox_state[k];
      sbox_state[k] = sbox_state[acc];
      sbox_state[acc] = t;
    end
    stream_i = 8'h00;
    stream_j = 8'h00;
  endfunction

  function automatic logic [7:0] next_keystream_byte();
    logic [7:0] t;
    logic [7:0] sum;
    stream_i = stream_i + 8'd1;
    stream_j = stream_j + sbox_state[stream_i];
    t = sbox_state[stream_i];
    sbox_state[stream_i] = sbox_state[stream_j];
    sbox_state[stream_j] = t;
    sum = sbox_state[stream_i] + sbox_state[stream_j];
    return sbox_state[sum];
  endfunction

  function automatic void track_rc4_item(logic [1:0] f, logic [7:0] d, logic l);
    logic [7:0] ks;
    case (f)
      FUNC_KEY: begin
        if (keys_stored < MAX_KEY_BYTES) begin
          key_bytes[keys_stored] = d;
          keys_stored++;
        end
        if (l) begin
          run_key_schedule(keys_stored);
          keys_stored = 0;
        end
      end
      FUNC_DATA: begin
        ks = next_keystream_byte();
        expected_cipher.push_back(d ^ ks);
      end
      FUNC_SKIP: begin
        ks = next_keystream_byte();
      end
      default: ;
    endcase
  endfunction

  task automatic flag_mismatch(string what, logic [7:0] want, logic [7:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch (%s) at %0t: expected %02h, got %02h", what, $realtime, want, got);
    end
  endtask

  // driver
  always @(posedge clk) begin : drive
    cipher_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_items.pop_front();
        in_valid <= 1'b1;
        func     <= nxt.func;
        data_in  <= nxt.data;
        last_key <= nxt.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin : watch
    logic [7:0] want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        track_rc4_item(func, data_in, last_key);
      end
      if (out_valid && out_ready) begin
        if (expected_cipher.size() == 0) begin
          flag_mismatch("unexpected transfer", 8'hxx, data_out);
        end else begin
          want = expected_cipher.pop_front();
          if (data_out !== want) begin
            flag_mismatch("data_out", want, data_out);
          end
        end
      end
    end
  end

  task automatic push_item(logic [1:0] f, logic [7:0] d, logic l);
    cipher_item_t it;
    it.func = f;
    it.data = d;
    it.last = l;
    pending_items.push_back(it);
    if (f != FUNC_NONE) begin
      items_queued++;
    end
  endtask

  task automatic push_key(int len, bit with_last);
    for (int k = 0; k < len; k++) begin
      push_item(FUNC_KEY, 8'($urandom), with_last && (k == len - 1));
    end
  endtask

  task automatic push_traffic(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 70) begin
        push_item(FUNC_DATA, 8'($urandom), ($urandom_range(9) == 0));
      end else if (r < 95) begin
        push_item(FUNC_SKIP, 8'($urandom), ($urandom_range(9) == 0));
      end else begin
        push_item(FUNC_NONE, 8'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic push_session();
    int r;
    int split;
    r = $urandom_range(99);
    if (r < 8) begin
      push_key($urandom_range(250, 262), 1'b1);
    end else if (r < 16) begin
      // key load interrupted by stream traffic
      split = $urandom_range(1, 6);
      push_key(split, 1'b0);
      push_traffic($urandom_range(1, 5));
      push_key($urandom_range(1, 8), 1'b1);
    end else if (r < 26) begin
      // keep running on the current key
    end else begin
      push_key($urandom_range(1, 16), 1'b1);
    end
    push_traffic($urandom_range(4, 40));
  endtask

  task automatic wait_sent();
    while (pending_items.size() != 0 || in_valid) @(negedge clk);
  endtask

  task automatic wait_results();
    wait_sent();
    while (expected_cipher.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(int send_pct, int recv_pct);
    int target;
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    target = items_queued + ITEMS_PER_PHASE;
    while (items_queued < target) begin
      push_session();
      while (pending_items.size() > 64) @(negedge clk);
    end
    wait_results();
  endtask

  initial begin
    fill_identity();
    keys_stored = 0;
    stream_i = 8'h00;
    stream_j = 8'h00;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // stream on the reset table, ignored selector, stray flags
    push_item(FUNC_DATA, 8'h00, 1'b0);
    push_item(FUNC_DATA, 8'hFF, 1'b0);
    push_item(FUNC_SKIP, 8'h5A, 1'b1);
    push_item(FUNC_NONE, 8'hFF, 1'b1);
    push_item(FUNC_DATA, 8'hA5, 1'b1);
    push_item(FUNC_NONE, 8'h00, 1'b0);
    // one-byte keys at both extremes, then a three-byte key
    push_item(FUNC_KEY, 8'h00, 1'b1);
    push_item(FUNC_DATA, 8'h00, 1'b0);
    push_item(FUNC_DATA, 8'hFF, 1'b0);
    push_item(FUNC_KEY, 8'hFF, 1'b1);
    push_item(FUNC_SKIP, 8'h00, 1'b0);
    push_item(FUNC_DATA, 8'h3C, 1'b0);
    push_item(FUNC_KEY, 8'h01, 1'b0);
    push_item(FUNC_KEY, 8'h80, 1'b0);
    push_item(FUNC_KEY, 8'h7F, 1'b1);
    push_item(FUNC_DATA, 8'hC3, 1'b0);
    push_item(FUNC_DATA, 8'h81, 1'b0);
    wait_results();

    // full key store, then overflow bytes with the flag on an ignored byte
    push_key(256, 1'b1);
    push_item(FUNC_DATA, 8'h12, 1'b0);
    push_key(259, 1'b1);
    push_item(FUNC_DATA, 8'hED, 1'b0);
    push_item(FUNC_DATA, 8'h00, 1'b0);
    wait_results();

    run_phase(0, 0);
    run_phase(47, 0);
    run_phase(0, 47);
    run_phase(35, 35);

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && expected_cipher.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (expected_cipher.size() != 0) begin
        $display("%0d expected bytes never arrived", expected_cipher.size());
      end
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("timeout with %0d bytes outstanding", expected_cipher.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: sim.f
rtl/rc4_pkg.sv
rtl/rc4_ram.sv
rtl/rc4_dp.sv
rtl/rc4_ctrl.sv
rtl/rc4_stream_cipher_top.sv
verif/rc4_stream_cipher_top_test.sv
